// ----- design/wmis_pkg.sv -----
// ----------------------------------------------------------------------------
// Wave motion IMU synthesizer package
// Shared widths, fixed-point constants, register indexes and saturation
// helpers for the synthesizer core and its CORDIC pipeline.
// ----------------------------------------------------------------------------
package wmis_pkg;

    localparam int TIME_BITS      = 40;
    localparam int PHASE_BITS     = 48;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    localparam int CORDIC_STEPS   = 24;
    localparam int CORDIC_LATENCY = CORDIC_STEPS + 2;

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [32:0] ATAN_TURNS [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

    localparam logic [PHASE_BITS-1:0] SIXTH_TURN  = 48'd46912496118443;
    localparam logic [31:0]           YAW_RATE_WORD = 32'd4691250;
    localparam logic signed [21:0]    YAW_DOT_Q24 = 22'sd1756861;
    localparam logic [30:0]           OMEGA_Q8    = 31'd1608495439;
    localparam logic signed [25:0]    GRAV_Q20    = 26'sd10283018;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROLL_AMPLITUDE  = 4'd0,
        REG_PITCH_AMPLITUDE = 4'd1,
        REG_HEAVE_AMPLITUDE = 4'd2,
        REG_ROLL_RATE       = 4'd3,
        REG_PITCH_RATE      = 4'd4,
        REG_HEAVE_RATE      = 4'd5,
        REG_FIELD_NORTH     = 4'd6,
        REG_FIELD_DOWN      = 4'd7
    } cfg_index_t;

    localparam logic [29:0]        RST_ROLL_AMPLITUDE  = 30'd47721859;
    localparam logic [29:0]        RST_PITCH_AMPLITUDE = 30'd23860929;
    localparam logic [21:0]        RST_HEAVE_AMPLITUDE = 22'd314573;
    localparam logic [31:0]        RST_ROLL_RATE       = 32'd46912496;
    localparam logic [31:0]        RST_PITCH_RATE      = 32'd35184372;
    localparam logic [31:0]        RST_HEAVE_RATE      = 32'd56294995;
    localparam logic signed [22:0] RST_FIELD_NORTH     = 23'sd1638400;
    localparam logic signed [22:0] RST_FIELD_DOWN      = 23'sd2621440;

    function automatic logic signed [24:0] sat25(input logic signed [31:0] v);
        logic signed [24:0] r;
        if (v > 32'sd16777215) begin
            r = 25'sd16777215;
        end else if (v < -32'sd16777216) begin
            r = -25'sd16777216;
        end else begin
            r = 25'(v);
        end
        return r;
    endfunction

    function automatic logic signed [22:0] sat23(input logic signed [31:0] v);
        logic signed [22:0] r;
        if (v > 32'sd4194303) begin
            r = 23'sd4194303;
        end else if (v < -32'sd4194304) begin
            r = -23'sd4194304;
        end else begin
            r = 23'(v);
        end
        return r;
    endfunction

endpackage

// ----- design/wave_motion_imu_synthesizer_core.sv -----
// ----------------------------------------------------------------------------
// Wave motion IMU synthesizer core
// Turns a scenario time into gyro, accelerometer and magnetometer readings
// of a boat rolling, pitching and heaving on a steady yaw sweep.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Ports                         | Contents
//  s_       | in        | s_valid s_ready s_time_us     | scenario time, us
//  m_       | out       | m_valid m_ready m_gyro_* ...  | one reading per item
//  cfg_     | in        | cfg_wen cfg_index cfg_data    | register writes
//
// One item enters per cycle unless the output item is stalled. The pipeline
// holds two chained 26-stage CORDIC banks plus phase and rotation stages.
// Reset clears the valid bits of every stage and loads the default registers.
// When the output item is not taken, the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module wave_motion_imu_synthesizer_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [wmis_pkg::TIME_BITS-1:0]       s_time_us,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [31:0]                   m_gyro_x,
    output logic signed [31:0]                   m_gyro_y,
    output logic signed [31:0]                   m_gyro_z,
    output logic signed [24:0]                   m_accel_x,
    output logic signed [24:0]                   m_accel_y,
    output logic signed [24:0]                   m_accel_z,
    output logic signed [22:0]                   m_mag_x,
    output logic signed [22:0]                   m_mag_y,
    output logic signed [22:0]                   m_mag_z,
    input  logic                                 cfg_wen,
    input  logic [wmis_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wmis_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import wmis_pkg::*;

    localparam int ST_BANKB = 3 + CORDIC_LATENCY;
    localparam int ST_C1    = ST_BANKB + CORDIC_LATENCY + 1;
    localparam int NSTAGE   = ST_C1 + 5;
    localparam int YAW_DLY  = ST_BANKB - 2;

    // Configuration registers and derived rate amplitudes.
    logic [29:0]        roll_amp_reg, pitch_amp_reg;
    logic [21:0]        heave_amp_reg;
    logic [31:0]        roll_rate_reg, pitch_rate_reg, heave_rate_reg;
    logic signed [22:0] field_n_reg, field_d_reg;
    logic [31:0]        roll_rp_reg, pitch_rp_reg;
    logic [28:0]        roll_ramp_reg, pitch_ramp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_amp_reg   <= RST_ROLL_AMPLITUDE;
            pitch_amp_reg  <= RST_PITCH_AMPLITUDE;
            heave_amp_reg  <= RST_HEAVE_AMPLITUDE;
            roll_rate_reg  <= RST_ROLL_RATE;
            pitch_rate_reg <= RST_PITCH_RATE;
            heave_rate_reg <= RST_HEAVE_RATE;
            field_n_reg    <= RST_FIELD_NORTH;
            field_d_reg    <= RST_FIELD_DOWN;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_ROLL_AMPLITUDE:  roll_amp_reg   <= cfg_data[29:0];
                REG_PITCH_AMPLITUDE: pitch_amp_reg  <= cfg_data[29:0];
                REG_HEAVE_AMPLITUDE: heave_amp_reg  <= cfg_data[21:0];
                REG_ROLL_RATE:       roll_rate_reg  <= cfg_data[31:0];
                REG_PITCH_RATE:      pitch_rate_reg <= cfg_data[31:0];
                REG_HEAVE_RATE:      heave_rate_reg <= cfg_data[31:0];
                REG_FIELD_NORTH:     field_n_reg    <= signed'(cfg_data[22:0]);
                REG_FIELD_DOWN:      field_d_reg    <= signed'(cfg_data[22:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        roll_rp_reg    <= 32'((62'(roll_amp_reg) * 62'(roll_rate_reg)) >> 30);
        pitch_rp_reg   <= 32'((62'(pitch_amp_reg) * 62'(pitch_rate_reg)) >> 30);
        roll_ramp_reg  <= 29'((63'(roll_rp_reg) * 63'(OMEGA_Q8)) >> 34);
        pitch_ramp_reg <= 29'((63'(pitch_rp_reg) * 63'(OMEGA_Q8)) >> 34);
    end

    // Pipeline control.
    logic [NSTAGE-1:0] valid_reg;
    logic              pipe_en;

    assign pipe_en = !valid_reg[NSTAGE-1] || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[NSTAGE-2:0], s_valid};
        end
    end

    // Phase generation: time register, partial products, phase sums.
    logic [PHASE_BITS-1:0] t_reg;
    logic [31:0]           rate_w [4];
    logic [PHASE_BITS-1:0] off_w [4];
    logic [PHASE_BITS-1:0] lo_reg [4];
    logic [15:0]           hi_reg [4];
    logic [PHASE_BITS-1:0] ph_reg [4];

    assign rate_w[0] = roll_rate_reg;
    assign rate_w[1] = pitch_rate_reg;
    assign rate_w[2] = heave_rate_reg;
    assign rate_w[3] = YAW_RATE_WORD;
    assign off_w[0]  = '0;
    assign off_w[1]  = SIXTH_TURN;
    assign off_w[2]  = '0;
    assign off_w[3]  = SIXTH_TURN;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            t_reg <= PHASE_BITS'(s_time_us);
            for (int k = 0; k < 4; k++) begin
                lo_reg[k] <= PHASE_BITS'(64'(t_reg[31:0]) * 64'(rate_w[k]));
                hi_reg[k] <= 16'(48'(t_reg[47:32]) * 48'(rate_w[k]));
                ph_reg[k] <= lo_reg[k] + {hi_reg[k], 32'd0} + off_w[k];
            end
        end
    end

    // First CORDIC bank: roll, pitch and heave phases.
    logic signed [31:0] cos_r, sin_r, cos_p, sin_p, sin_h;

    wmis_cordic u_cordic_roll (
        .aclk(aclk), .en(pipe_en), .angle_i(ph_reg[0][47:16]),
        .cos_o(cos_r), .sin_o(sin_r)
    );
    wmis_cordic u_cordic_pitch (
        .aclk(aclk), .en(pipe_en), .angle_i(ph_reg[1][47:16]),
        .cos_o(cos_p), .sin_o(sin_p)
    );
    wmis_cordic u_cordic_heave (
        .aclk(aclk), .en(pipe_en), .angle_i(ph_reg[2][47:16]),
        .cos_o(), .sin_o(sin_h)
    );

    // Swing angles, angle rates and heave acceleration.
    logic signed [31:0] phi_next, theta_next, dphi_next, dtheta_next;
    logic signed [24:0] heave_next;
    logic signed [31:0] phi_reg, theta_reg, dphi_reg, dtheta_reg;
    logic signed [24:0] heave_reg;
    logic        [31:0] yaw_dly_reg [YAW_DLY];

    assign phi_next    = 32'((63'(sin_r) * 63'(signed'({1'b0, roll_amp_reg}))) >>> 30);
    assign theta_next  = 32'((63'(sin_p) * 63'(signed'({1'b0, pitch_amp_reg}))) >>> 30);
    assign dphi_next   = 32'((62'(cos_r) * 62'(signed'({1'b0, roll_ramp_reg}))) >>> 30);
    assign dtheta_next = 32'((62'(cos_p) * 62'(signed'({1'b0, pitch_ramp_reg}))) >>> 30);
    assign heave_next  = 25'((55'(sin_h) * 55'(signed'({1'b0, heave_amp_reg}))) >>> 30);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            phi_reg        <= phi_next;
            theta_reg      <= theta_next;
            dphi_reg       <= dphi_next;
            dtheta_reg     <= dtheta_next;
            heave_reg      <= heave_next;
            yaw_dly_reg[0] <= ph_reg[3][47:16];
            for (int k = 1; k < YAW_DLY; k++) begin
                yaw_dly_reg[k] <= yaw_dly_reg[k-1];
            end
        end
    end

    // Second CORDIC bank: yaw, pitch angle and roll angle.
    logic signed [31:0] tr0, tr1, tr2, tr3, tr4, tr5;

    wmis_cordic u_cordic_yaw (
        .aclk(aclk), .en(pipe_en), .angle_i(yaw_dly_reg[YAW_DLY-1]),
        .cos_o(tr0), .sin_o(tr1)
    );
    wmis_cordic u_cordic_theta (
        .aclk(aclk), .en(pipe_en), .angle_i(theta_reg),
        .cos_o(tr2), .sin_o(tr3)
    );
    wmis_cordic u_cordic_phi (
        .aclk(aclk), .en(pipe_en), .angle_i(phi_reg),
        .cos_o(tr4), .sin_o(tr5)
    );

    logic signed [31:0] dphi_dly_reg [CORDIC_LATENCY];
    logic signed [31:0] dtheta_dly_reg [CORDIC_LATENCY];
    logic signed [24:0] heave_dly_reg [CORDIC_LATENCY];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dphi_dly_reg[0]   <= dphi_reg;
            dtheta_dly_reg[0] <= dtheta_reg;
            heave_dly_reg[0]  <= heave_reg;
            for (int k = 1; k < CORDIC_LATENCY; k++) begin
                dphi_dly_reg[k]   <= dphi_dly_reg[k-1];
                dtheta_dly_reg[k] <= dtheta_dly_reg[k-1];
                heave_dly_reg[k]  <= heave_dly_reg[k-1];
            end
        end
    end

    // Rotation stage 1.
    logic signed [25:0] nz;
    logic signed [23:0] c1_dpc_reg;
    logic signed [31:0] c1_g0_reg, c1_gd4_reg, c1_gd5_reg;
    logic signed [27:0] c1_apx_reg, c1_apz_reg;
    logic signed [24:0] c1_ax_reg, c1_ay_reg;
    logic signed [31:0] c1_tr2_reg, c1_tr3_reg, c1_tr4_reg, c1_tr5_reg;

    assign nz = 26'(heave_dly_reg[CORDIC_LATENCY-1]) - GRAV_Q20;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c1_dpc_reg <= 24'((54'(tr2) * 54'(YAW_DOT_Q24)) >>> 30);
            c1_g0_reg  <= dphi_dly_reg[CORDIC_LATENCY-1]
                          - 32'((54'(tr3) * 54'(YAW_DOT_Q24)) >>> 30);
            c1_gd4_reg <= 32'((64'(dtheta_dly_reg[CORDIC_LATENCY-1]) * 64'(tr4)) >>> 30);
            c1_gd5_reg <= 32'((64'(dtheta_dly_reg[CORDIC_LATENCY-1]) * 64'(tr5)) >>> 30);
            c1_apx_reg <= 28'((-(58'(tr3) * 58'(nz))) >>> 30);
            c1_apz_reg <= 28'((58'(tr2) * 58'(nz)) >>> 30);
            c1_ax_reg  <= 25'((55'(tr0) * 55'(field_n_reg)) >>> 30);
            c1_ay_reg  <= 25'((-(55'(tr1) * 55'(field_n_reg))) >>> 30);
            c1_tr2_reg <= tr2;
            c1_tr3_reg <= tr3;
            c1_tr4_reg <= tr4;
            c1_tr5_reg <= tr5;
        end
    end

    // Rotation stage 2.
    logic signed [25:0] c2_dc4_reg, c2_dc5_reg;
    logic signed [31:0] c2_g0_reg, c2_gd4_reg, c2_gd5_reg;
    logic signed [27:0] c2_apx_reg, c2_aby_reg, c2_abz_reg;
    logic signed [56:0] c2_q2_reg, c2_q3_reg;
    logic signed [54:0] c2_f2_reg, c2_f3_reg;
    logic signed [24:0] c2_ay_reg;
    logic signed [31:0] c2_tr4_reg, c2_tr5_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c2_dc4_reg <= 26'((56'(c1_dpc_reg) * 56'(c1_tr4_reg)) >>> 30);
            c2_dc5_reg <= 26'((56'(c1_dpc_reg) * 56'(c1_tr5_reg)) >>> 30);
            c2_g0_reg  <= c1_g0_reg;
            c2_gd4_reg <= c1_gd4_reg;
            c2_gd5_reg <= c1_gd5_reg;
            c2_apx_reg <= c1_apx_reg;
            c2_aby_reg <= 28'((60'(c1_tr5_reg) * 60'(c1_apz_reg)) >>> 30);
            c2_abz_reg <= 28'((60'(c1_tr4_reg) * 60'(c1_apz_reg)) >>> 30);
            c2_q2_reg  <= 57'(c1_tr2_reg) * 57'(c1_ax_reg);
            c2_q3_reg  <= 57'(c1_tr3_reg) * 57'(c1_ax_reg);
            c2_f2_reg  <= 55'(c1_tr2_reg) * 55'(field_d_reg);
            c2_f3_reg  <= 55'(c1_tr3_reg) * 55'(field_d_reg);
            c2_ay_reg  <= c1_ay_reg;
            c2_tr4_reg <= c1_tr4_reg;
            c2_tr5_reg <= c1_tr5_reg;
        end
    end

    // Rotation stage 3.
    logic signed [31:0] c3_g0_reg, c3_g1_reg, c3_g2_reg;
    logic signed [27:0] c3_apx_reg, c3_aby_reg, c3_abz_reg;
    logic signed [27:0] c3_mpx_reg, c3_mpz_reg;
    logic signed [24:0] c3_ay_reg;
    logic signed [31:0] c3_tr4_reg, c3_tr5_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c3_g0_reg  <= c2_g0_reg;
            c3_g1_reg  <= c2_gd4_reg + 32'(c2_dc5_reg);
            c3_g2_reg  <= 32'(c2_dc4_reg) - c2_gd5_reg;
            c3_apx_reg <= c2_apx_reg;
            c3_aby_reg <= c2_aby_reg;
            c3_abz_reg <= c2_abz_reg;
            c3_mpx_reg <= 28'((58'(c2_q2_reg) - 58'(c2_f3_reg)) >>> 30);
            c3_mpz_reg <= 28'((58'(c2_q3_reg) + 58'(c2_f2_reg)) >>> 30);
            c3_ay_reg  <= c2_ay_reg;
            c3_tr4_reg <= c2_tr4_reg;
            c3_tr5_reg <= c2_tr5_reg;
        end
    end

    // Rotation stage 4.
    logic signed [31:0] c4_g0_reg, c4_g1_reg, c4_g2_reg;
    logic signed [27:0] c4_apx_reg, c4_aby_reg, c4_abz_reg, c4_mpx_reg;
    logic signed [59:0] c4_r4_reg, c4_r5_reg, c4_r5a_reg, c4_r4z_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c4_g0_reg  <= c3_g0_reg;
            c4_g1_reg  <= c3_g1_reg;
            c4_g2_reg  <= c3_g2_reg;
            c4_apx_reg <= c3_apx_reg;
            c4_aby_reg <= c3_aby_reg;
            c4_abz_reg <= c3_abz_reg;
            c4_mpx_reg <= c3_mpx_reg;
            c4_r4_reg  <= 60'(c3_tr4_reg) * 60'(c3_ay_reg);
            c4_r5_reg  <= 60'(c3_tr5_reg) * 60'(c3_mpz_reg);
            c4_r5a_reg <= 60'(c3_tr5_reg) * 60'(c3_ay_reg);
            c4_r4z_reg <= 60'(c3_tr4_reg) * 60'(c3_mpz_reg);
        end
    end

    // Output register.
    logic signed [31:0] mby, mbz;

    assign mby = 32'((61'(c4_r4_reg) + 61'(c4_r5_reg)) >>> 30);
    assign mbz = 32'((61'(c4_r4z_reg) - 61'(c4_r5a_reg)) >>> 30);

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_gyro_x  <= c4_g0_reg;
            m_gyro_y  <= c4_g1_reg;
            m_gyro_z  <= c4_g2_reg;
            m_accel_x <= sat25(32'(c4_apx_reg));
            m_accel_y <= sat25(32'(c4_aby_reg));
            m_accel_z <= sat25(32'(c4_abz_reg));
            m_mag_x   <= sat23(32'(c4_mpx_reg));
            m_mag_y   <= sat23(mby);
            m_mag_z   <= sat23(mbz);
        end
    end

    a_valid_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en |=> valid_reg[1] == $past(valid_reg[0]))
        else $error("Pipeline valid bit did not advance with its item.");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(valid_reg))
        else $error("Pipeline moved while the output item was stalled.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Output item valid right after reset.");

endmodule

// ----- design/wmis_cordic.sv -----
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine and cosine
// Folds a 32-bit turn fraction into a quarter turn either side of zero and
// runs one rotation step per register stage. Results are Q30.
// ----------------------------------------------------------------------------
module wmis_cordic (
    input  logic               aclk,
    input  logic               en,
    input  logic        [31:0] angle_i,
    output logic signed [31:0] cos_o,
    output logic signed [31:0] sin_o
);
    import wmis_pkg::*;

    logic signed [32:0] x_reg [CORDIC_STEPS+1];
    logic signed [32:0] y_reg [CORDIC_STEPS+1];
    logic signed [32:0] z_reg [CORDIC_STEPS+1];
    logic               flip_reg [CORDIC_STEPS+1];
    logic               fold;

    assign fold = angle_i[31] ^ angle_i[30];

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= 33'(signed'({angle_i[31] ^ fold, angle_i[30:0]}));
            flip_reg[0] <= fold;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (!z_reg[i][32]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TURNS[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TURNS[i];
                end
                flip_reg[i+1] <= flip_reg[i];
            end
            cos_o <= flip_reg[CORDIC_STEPS] ? 32'(-x_reg[CORDIC_STEPS])
                                            : 32'(x_reg[CORDIC_STEPS]);
            sin_o <= flip_reg[CORDIC_STEPS] ? 32'(-y_reg[CORDIC_STEPS])
                                            : 32'(y_reg[CORDIC_STEPS]);
        end
    end

endmodule

// ----- test/tb_wave_motion_imu_synthesizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wave motion IMU synthesizer core testbench
// Drives scenario times through the core under random source gaps and sink
// stalls across several register settings, and compares every reading field
// by field with an in-bench fixed-point predictor of the motion, the CORDIC
// sine and cosine and the body-frame rotations.
// ----------------------------------------------------------------------------
module tb_wave_motion_imu_synthesizer_core;
    import wmis_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 4'd15;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 80;

    typedef struct {
        logic signed [31:0] gyro_x, gyro_y, gyro_z;
        logic signed [24:0] accel_x, accel_y, accel_z;
        logic signed [22:0] mag_x, mag_y, mag_z;
    } reading_t;

    class imu_scoreboard;
        longint unsigned roll_amp, pitch_amp, heave_amp;
        longint unsigned roll_rate, pitch_rate, heave_rate;
        longint field_n, field_d;
        reading_t pending[$];

        function void load_defaults();
            roll_amp   = RST_ROLL_AMPLITUDE;
            pitch_amp  = RST_PITCH_AMPLITUDE;
            heave_amp  = RST_HEAVE_AMPLITUDE;
            roll_rate  = RST_ROLL_RATE;
            pitch_rate = RST_PITCH_RATE;
            heave_rate = RST_HEAVE_RATE;
            field_n    = RST_FIELD_NORTH;
            field_d    = RST_FIELD_DOWN;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
            case (idx)
                REG_ROLL_AMPLITUDE:  roll_amp   = data[29:0];
                REG_PITCH_AMPLITUDE: pitch_amp  = data[29:0];
                REG_HEAVE_AMPLITUDE: heave_amp  = data[21:0];
                REG_ROLL_RATE:       roll_rate  = data;
                REG_PITCH_RATE:      pitch_rate = data;
                REG_HEAVE_RATE:      heave_rate = data;
                REG_FIELD_NORTH:     field_n    = longint'($signed(data[22:0]));
                REG_FIELD_DOWN:      field_d    = longint'($signed(data[22:0]));
                default: ;
            endcase
        endfunction

        function void sin_cos(logic [31:0] ang, output longint c, output longint s);
            logic [31:0] a;
            bit flip;
            longint x, y, z, nx;
            a = ang;
            flip = 0;
            if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
                a = a - 32'h8000_0000;
                flip = 1;
            end
            z = longint'($signed(a));
            x = longint'(CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(ATAN_TURNS[i]);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(ATAN_TURNS[i]);
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint swing_rate(longint unsigned amp, longint unsigned rate);
            longint unsigned p;
            p = (amp * rate) >> 30;
            return longint'((p * longint'(OMEGA_Q8)) >> 34);
        endfunction

        function longint clamp(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) << (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        // tr holds cos/sin of yaw, pitch and roll.
        function void to_body(longint tr[6], longint nx, longint nz,
                              output longint bx, output longint by, output longint bz);
            longint ax, ay, pz;
            ax = (tr[0] * nx) >>> 30;
            ay = (-tr[1] * nx) >>> 30;
            bx = (tr[2] * ax - tr[3] * nz) >>> 30;
            pz = (tr[3] * ax + tr[2] * nz) >>> 30;
            by = (tr[4] * ay + tr[5] * pz) >>> 30;
            bz = (-tr[5] * ay + tr[4] * pz) >>> 30;
        endfunction

        function reading_t predict(logic [TIME_BITS-1:0] t_us);
            longint unsigned t, mask, ph_r, ph_p, ph_h, ph_y;
            longint cr, sr, cp, sp, ch, sh, phi, theta, dphi, dtheta, dpc, heave;
            longint tr[6];
            longint vx, vy, vz;
            reading_t r;
            t = t_us;
            mask = (longint'(1) << PHASE_BITS) - 1;
            ph_r = (t * roll_rate) & mask;
            ph_p = (t * pitch_rate + longint'(SIXTH_TURN)) & mask;
            ph_h = (t * heave_rate) & mask;
            ph_y = (t * longint'(YAW_RATE_WORD) + longint'(SIXTH_TURN)) & mask;
            sin_cos(ph_r[47:16], cr, sr);
            sin_cos(ph_p[47:16], cp, sp);
            sin_cos(ph_h[47:16], ch, sh);
            phi    = (longint'(roll_amp) * sr) >>> 30;
            theta  = (longint'(pitch_amp) * sp) >>> 30;
            dphi   = (swing_rate(roll_amp, roll_rate) * cr) >>> 30;
            dtheta = (swing_rate(pitch_amp, pitch_rate) * cp) >>> 30;
            sin_cos(ph_y[47:16], tr[0], tr[1]);
            sin_cos(theta[31:0], tr[2], tr[3]);
            sin_cos(phi[31:0], tr[4], tr[5]);
            dpc = (longint'(YAW_DOT_Q24) * tr[2]) >>> 30;
            r.gyro_x = 32'(dphi - ((longint'(YAW_DOT_Q24) * tr[3]) >>> 30));
            r.gyro_y = 32'(((dtheta * tr[4]) >>> 30) + ((dpc * tr[5]) >>> 30));
            r.gyro_z = 32'(-((dtheta * tr[5]) >>> 30) + ((dpc * tr[4]) >>> 30));
            heave = (longint'(heave_amp) * sh) >>> 30;
            to_body(tr, 0, heave - longint'(GRAV_Q20), vx, vy, vz);
            r.accel_x = 25'(clamp(vx, 25));
            r.accel_y = 25'(clamp(vy, 25));
            r.accel_z = 25'(clamp(vz, 25));
            to_body(tr, field_n, field_d, vx, vy, vz);
            r.mag_x = 23'(clamp(vx, 23));
            r.mag_y = 23'(clamp(vy, 23));
            r.mag_z = 23'(clamp(vz, 23));
            return r;
        endfunction

        function void note_time(logic [TIME_BITS-1:0] t_us);
            pending.push_back(predict(t_us));
        endfunction

        function bit [8:0] check(reading_t got, output reading_t want);
            want = pending.pop_front();
            return {got.gyro_x != want.gyro_x, got.gyro_y != want.gyro_y,
                    got.gyro_z != want.gyro_z, got.accel_x != want.accel_x,
                    got.accel_y != want.accel_y, got.accel_z != want.accel_z,
                    got.mag_x != want.mag_x, got.mag_y != want.mag_y,
                    got.mag_z != want.mag_z};
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_wen;
    logic [TIME_BITS-1:0] s_time_us;
    logic signed [31:0] m_gyro_x, m_gyro_y, m_gyro_z;
    logic signed [24:0] m_accel_x, m_accel_y, m_accel_z;
    logic signed [22:0] m_mag_x, m_mag_y, m_mag_z;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    imu_scoreboard sb;
    int errors = 0;
    int items_in = 0;
    int readings_out = 0;
    int idle_cycles = 0;
    int settings = 0;
    bit src_burst = 0;
    bit snk_burst = 0;

    wave_motion_imu_synthesizer_core uut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    task automatic report(string what);
        errors++;
        if (errors <= 30) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    task automatic send(logic [TIME_BITS-1:0] t_us);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_time_us <= t_us;
        do @(posedge aclk); while (!s_ready);
        sb.note_time(t_us);
        items_in++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic load_setting(logic [31:0] ra, logic [31:0] pa, logic [31:0] ha,
                                logic [31:0] rr, logic [31:0] pr, logic [31:0] hr,
                                logic [31:0] fn, logic [31:0] fd);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_ROLL_AMPLITUDE, ra);
        write_reg(REG_PITCH_AMPLITUDE, pa);
        write_reg(REG_HEAVE_AMPLITUDE, ha);
        write_reg(REG_ROLL_RATE, rr);
        write_reg(REG_PITCH_RATE, pr);
        write_reg(REG_HEAVE_RATE, hr);
        write_reg(REG_FIELD_NORTH, fn);
        write_reg(REG_FIELD_DOWN, fd);
        settings++;
    endtask

    function automatic logic [TIME_BITS-1:0] random_time();
        case ($urandom_range(0, 3))
            0: return TIME_BITS'($urandom_range(0, 100000000));
            1: return TIME_BITS'({$urandom, $urandom} % 64'd86400000000);
            default: return TIME_BITS'({$urandom, $urandom});
        endcase
    endfunction

    task automatic random_items(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                src_burst = $urandom_range(0, 3) == 0;
                snk_burst = $urandom_range(0, 3) == 0;
            end
            send(random_time());
        end
    endtask

    // Sink: stalls a random number of cycles before taking each reading, except in sink bursts.
    initial begin
        reading_t got, want;
        bit [8:0] bad;
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = snk_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            readings_out++;
            got = '{m_gyro_x, m_gyro_y, m_gyro_z, m_accel_x, m_accel_y, m_accel_z,
                    m_mag_x, m_mag_y, m_mag_z};
            if (sb.pending.size() == 0) begin
                report("reading with no item outstanding");
            end else begin
                bad = sb.check(got, want);
                if (bad[8]) report($sformatf("gyro_x got %0d want %0d", got.gyro_x, want.gyro_x));
                if (bad[7]) report($sformatf("gyro_y got %0d want %0d", got.gyro_y, want.gyro_y));
                if (bad[6]) report($sformatf("gyro_z got %0d want %0d", got.gyro_z, want.gyro_z));
                if (bad[5]) report($sformatf("accel_x got %0d want %0d", got.accel_x, want.accel_x));
                if (bad[4]) report($sformatf("accel_y got %0d want %0d", got.accel_y, want.accel_y));
                if (bad[3]) report($sformatf("accel_z got %0d want %0d", got.accel_z, want.accel_z));
                if (bad[2]) report($sformatf("mag_x got %0d want %0d", got.mag_x, want.mag_x));
                if (bad[1]) report($sformatf("mag_y got %0d want %0d", got.mag_y, want.mag_y));
                if (bad[0]) report($sformatf("mag_z got %0d want %0d", got.mag_z, want.mag_z));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sb = new();
        sb.load_defaults();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_time_us = '0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default registers: time extremes and a few ordinary instants.
        send('0);
        send('1);
        send(TIME_BITS'(1));
        send(TIME_BITS'(1000000));
        send(TIME_BITS'(60000000));
        send({1'b1, {(TIME_BITS-1){1'b0}}});
        send(TIME_BITS'(40'h55_5555_5555));
        send(TIME_BITS'(40'hAA_AAAA_AAAA));

        // Largest amplitudes and rates, extreme fields.
        load_setting(32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3F_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h003F_FFFF, 32'h0040_0000);
        write_reg(REG_UNUSED, 32'h0000_1234);
        for (int i = 0; i < 6; i++) send(random_time());
        send('1);

        // Upper ends of the nominal ranges, opposite fields.
        load_setting(32'd536870912, 32'd536870912, 32'd2097152,
                     32'd123456789, 32'd987654321, 32'd55555555,
                     32'h0040_0000, 32'h003F_FFFF);
        for (int i = 0; i < 4; i++) send(random_time());

        // All zero: level boat, no heave, no field.
        load_setting(0, 0, 0, 0, 0, 0, 0, 0);
        send('0);
        send('1);
        send(random_time());

        for (int phase = 0; phase < 6; phase++) begin
            load_setting($urandom_range(0, 536870912), $urandom_range(0, 536870912),
                         $urandom_range(0, 2097152),
                         phase == 0 ? 32'hFFFF_FFFF : $urandom, $urandom >> $urandom_range(0, 8),
                         $urandom >> $urandom_range(0, 8),
                         $urandom, $urandom);
            random_items(75);
            drain();
            random_items(75);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d items and %0d readings over %0d register settings,",
                 items_in, readings_out, settings + 1);
        $display("with random source gaps and sink stalls and zero-gap bursts.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/wmis_pkg.sv
design/wmis_cordic.sv
design/wave_motion_imu_synthesizer_core.sv
test/tb_wave_motion_imu_synthesizer_core.sv
